>>> hdl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants for the FPU compare and status unit
// Operation codes, status word layout and the request/result payloads.
// ----------------------------------------------------------------------------
`default_nettype none
package fcs_pkg;

  typedef enum logic [1:0] {
    OP_COMPARE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [4:0]  IDX_IMPL = 5'd0;
  localparam logic [4:0]  IDX_STATUS = 5'd31;

  localparam logic [31:0] WRITABLE_MASK = 32'h0183ffff;
  localparam logic [31:0] CAUSE_FIELD   = 32'h0003f000;
  localparam logic [31:0] IMPL_WORD     = 32'h00000a00;
  localparam logic [31:0] SP_EXP        = 32'h7f800000;
  localparam logic [31:0] SP_QUIET      = 32'h00400000;
  localparam logic [63:0] DP_EXP        = 64'h7ff0000000000000;
  localparam logic [63:0] DP_QUIET      = 64'h0008000000000000;
  localparam logic [31:0] SP_FRAC       = 32'h007fffff;
  localparam logic [63:0] DP_FRAC       = 64'h000fffffffffffff;

  localparam int BIT_FLAG_INV   = 6;
  localparam int BIT_ENA_INV    = 11;
  localparam int BIT_CAUSE_INV  = 16;
  localparam int BIT_UNIMPL     = 17;
  localparam int BIT_COND       = 23;

  typedef struct packed {
    logic [1:0]  operation;
    logic        double_format;
    logic [63:0] left_operand;
    logic [63:0] right_operand;
    logic [3:0]  predicate;
    logic [4:0]  control_index;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic        condition_flag;
    logic        fp_exception;
    logic [31:0] read_data;
  } rsp_t;

  // Compare classification handed to the status update
  typedef struct packed {
    logic a_nan;
    logic b_nan;
    logic a_inv;
    logic b_inv;
    logic less;
    logic equal;
  } cmp_t;

endpackage
`default_nettype wire

>>> hdl/fcs_if.sv
// ----------------------------------------------------------------------------
// fcs_if: valid/ready channel carrying one payload
// Generic stream interface used for the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface fcs_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/fcs_cmp.sv
// ----------------------------------------------------------------------------
// fcs_cmp: operand classifier and sign-magnitude comparator
// Detects NaN operands and invalid causes and orders the two operands.
// ----------------------------------------------------------------------------
`default_nettype none
module fcs_cmp (
  input  wire logic                dbl,
  input  wire logic [63:0]         a_in,
  input  wire logic [63:0]         b_in,
  input  wire logic                signaling,
  output fcs_pkg::cmp_t            cmp
);
  logic [63:0] a, b, expm, qbit, fracm, sgn, am, bm;
  logic        as, bs, an, bn, mlt, meq;

  // Select format masks and trim singles to the low word
  always_comb begin
    if (dbl) begin
      a = a_in;
      b = b_in;
      expm = fcs_pkg::DP_EXP;
      qbit = fcs_pkg::DP_QUIET;
      fracm = fcs_pkg::DP_FRAC;
      sgn = 64'h8000000000000000;
    end else begin
      a = {32'd0, a_in[31:0]};
      b = {32'd0, b_in[31:0]};
      expm = {32'd0, fcs_pkg::SP_EXP};
      qbit = {32'd0, fcs_pkg::SP_QUIET};
      fracm = {32'd0, fcs_pkg::SP_FRAC};
      sgn = 64'h0000000080000000;
    end
    an = ((a & expm) == expm) && ((a & fracm) != 64'd0);
    bn = ((b & expm) == expm) && ((b & fracm) != 64'd0);
    am = a & ~sgn;
    bm = b & ~sgn;
    as = (a & sgn) != 64'd0;
    bs = (b & sgn) != 64'd0;
    mlt = am < bm;
    meq = am == bm;
  end

  // Order by sign and magnitude, zeros equal
  always_comb begin
    cmp.a_nan = an;
    cmp.b_nan = bn;
    cmp.a_inv = an && (signaling || ((a & qbit) != 64'd0));
    cmp.b_inv = bn && (signaling || ((b & qbit) != 64'd0));
    cmp.less = 1'b0;
    cmp.equal = 1'b0;
    if (am == 64'd0 && bm == 64'd0) begin
      cmp.equal = 1'b1;
    end else if (as != bs) begin
      cmp.less = as;
    end else if (!as) begin
      cmp.less = mlt;
      cmp.equal = meq;
    end else begin
      cmp.less = !mlt && !meq;
      cmp.equal = meq;
    end
  end
endmodule
`default_nettype wire

>>> hdl/fpu_compare_and_status_top.sv
// ----------------------------------------------------------------------------
// fpu_compare_and_status_top: coprocessor-1 compare and control/status unit
// Channel  Dir  Ports
// in       in   in_valid, in_ready, in_data (fcs_pkg::req_t)
// out      out  out_valid, out_ready, out_data (fcs_pkg::rsp_t)
// One request per cycle while out_ready does not hold the result register; result appears the cycle after acceptance.
// Compare and status update run in one pass between input and result register.
// The result register holds while out_ready is low; in_ready follows it.
// Synchronous active-low reset clears the status word and valid.
// ----------------------------------------------------------------------------
`default_nettype none
module fpu_compare_and_status_top (
  input  wire logic clk,
  input  wire logic rst_n,
  fcs_if.sink       in_if,
  fcs_if.source     out_if
);
  fcs_pkg::req_t req;
  fcs_pkg::cmp_t cmp;
  fcs_pkg::rsp_t rsp_r, rsp_nxt;
  logic          vld_r;
  logic [31:0]   status_r, status_nxt;
  logic          acc, trap;

  assign req = fcs_pkg::req_t'(in_if.data);
  assign in_if.ready = !vld_r || out_if.ready;
  assign acc = in_if.valid && in_if.ready;
  assign out_if.valid = vld_r;
  assign out_if.data = rsp_r;

  fcs_cmp u_cmp (
    .dbl       (req.double_format),
    .a_in      (req.left_operand),
    .b_in      (req.right_operand),
    .signaling (req.predicate[3]),
    .cmp       (cmp)
  );

  // Compute next status and result for the accepted request
  always_comb begin
    status_nxt = status_r;
    rsp_nxt = '0;
    trap = 1'b0;
    case (fcs_pkg::op_t'(req.operation))
      fcs_pkg::OP_COMPARE: begin
        status_nxt = status_r & ~fcs_pkg::CAUSE_FIELD;
        if (cmp.a_inv || cmp.b_inv) begin
          status_nxt[fcs_pkg::BIT_CAUSE_INV] = 1'b1;
          if (status_r[fcs_pkg::BIT_ENA_INV]) trap = 1'b1;
          else status_nxt[fcs_pkg::BIT_FLAG_INV] = 1'b1;
        end
        if (!trap) begin
          if (cmp.a_nan || cmp.b_nan) status_nxt[fcs_pkg::BIT_COND] = req.predicate[0];
          else status_nxt[fcs_pkg::BIT_COND] = (req.predicate[2] && cmp.less) ||
                                                (req.predicate[1] && cmp.equal);
        end
      end
      fcs_pkg::OP_WRITE: begin
        if (req.control_index == fcs_pkg::IDX_STATUS) begin
          status_nxt = req.write_value & fcs_pkg::WRITABLE_MASK;
          trap = status_nxt[fcs_pkg::BIT_UNIMPL] ||
                 ((status_nxt[16:12] & status_nxt[11:7]) != 5'd0);
        end
      end
      fcs_pkg::OP_READ: begin
        if (req.control_index == fcs_pkg::IDX_IMPL) rsp_nxt.read_data = fcs_pkg::IMPL_WORD;
        else if (req.control_index == fcs_pkg::IDX_STATUS) rsp_nxt.read_data = status_r;
      end
      default: ;
    endcase
    rsp_nxt.condition_flag = status_nxt[fcs_pkg::BIT_COND];
    rsp_nxt.fp_exception = trap;
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      status_r <= '0;
    end else begin
      if (acc) begin
        vld_r <= 1'b1;
        status_r <= status_nxt;
      end else if (out_if.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (acc) rsp_r <= rsp_nxt;
  end
endmodule
`default_nettype wire

>>> hdl/fcs_checker.sv
// ----------------------------------------------------------------------------
// fcs_checker: port-level checks for the compare and status unit
// Watches handshakes and result payload over time.
// ----------------------------------------------------------------------------
`default_nettype none
module fcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [33:0] out_data
);
  // Accepted request yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("no result after request");
  // Free output means ready input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled while empty");
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  // Exception only with zero read data
  a_exc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[32] |-> out_data[31:0] == 32'd0) else $error("exception with read");
endmodule

bind fpu_compare_and_status_top fcs_checker u_fcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the FPU compare and status unit
// Drives compare, control write, control read and no-op requests with random gaps,
// predicts each result from a local copy of the status word and checks the
// result stream in order, with random and long back-pressure on the output.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  localparam int NUM_RANDOM = 930;
  localparam int PAUSE_AT   = 600;

  logic clk;
  logic rst_n;

  fcs_if #(.W($bits(fcs_pkg::req_t))) in_ch ();
  fcs_if #(.W($bits(fcs_pkg::rsp_t))) out_ch ();

  fpu_compare_and_status_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  fcs_pkg::req_t pending_reqs[$];
  fcs_pkg::rsp_t expected_rsps[$];
  logic [31:0]   status_copy;
  int            sent_count;
  int            cycle_count;
  int            mismatch_count;
  bit            paused_once;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Update the local status word for one request and return its result
  function automatic fcs_pkg::rsp_t predict_status(fcs_pkg::req_t r);
    fcs_pkg::rsp_t res;
    logic [63:0]   a, b, sgn, expm, qbit, fracm, am, bm;
    bit            an, bn, sig, trap, less, equal, cond, as_, bs_;
    res = '0;
    trap = 1'b0;
    less = 1'b0;
    equal = 1'b0;
    case (fcs_pkg::op_t'(r.operation))
      fcs_pkg::OP_COMPARE: begin
        status_copy &= ~fcs_pkg::CAUSE_FIELD;
        if (r.double_format) begin
          a = r.left_operand;
          b = r.right_operand;
          sgn = 64'h8000000000000000;
          expm = fcs_pkg::DP_EXP;
          qbit = fcs_pkg::DP_QUIET;
          fracm = fcs_pkg::DP_FRAC;
        end else begin
          a = {32'd0, r.left_operand[31:0]};
          b = {32'd0, r.right_operand[31:0]};
          sgn = 64'h80000000;
          expm = {32'd0, fcs_pkg::SP_EXP};
          qbit = {32'd0, fcs_pkg::SP_QUIET};
          fracm = {32'd0, fcs_pkg::SP_FRAC};
        end
        sig = r.predicate[3];
        an = ((a & expm) == expm) && ((a & fracm) != 0);
        bn = ((b & expm) == expm) && ((b & fracm) != 0);
        // Invalid: set cause, then trap if enabled or else set the flag
        if ((an && (sig || (a & qbit) != 0)) || (bn && (sig || (b & qbit) != 0))) begin
          status_copy[fcs_pkg::BIT_CAUSE_INV] = 1'b1;
          if (status_copy[fcs_pkg::BIT_ENA_INV]) trap = 1'b1;
          else status_copy[fcs_pkg::BIT_FLAG_INV] = 1'b1;
        end
        if (!trap) begin
          if (an || bn) begin
            cond = r.predicate[0];
          end else begin
            am = a & ~sgn;
            bm = b & ~sgn;
            as_ = (a & sgn) != 0;
            bs_ = (b & sgn) != 0;
            if (am == 0 && bm == 0) equal = 1'b1;
            else if (as_ != bs_) less = as_;
            else if (!as_) begin
              less = am < bm;
              equal = am == bm;
            end else begin
              less = am > bm;
              equal = am == bm;
            end
            cond = (r.predicate[2] && less) || (r.predicate[1] && equal);
          end
          status_copy[fcs_pkg::BIT_COND] = cond;
        end
        res.fp_exception = trap;
      end
      fcs_pkg::OP_WRITE: begin
        if (r.control_index == fcs_pkg::IDX_STATUS) begin
          status_copy = r.write_value & fcs_pkg::WRITABLE_MASK;
          res.fp_exception = status_copy[fcs_pkg::BIT_UNIMPL] ||
                             ((status_copy[16:12] & status_copy[11:7]) != 0);
        end
      end
      fcs_pkg::OP_READ: begin
        if (r.control_index == fcs_pkg::IDX_IMPL) res.read_data = fcs_pkg::IMPL_WORD;
        else if (r.control_index == fcs_pkg::IDX_STATUS) res.read_data = status_copy;
      end
      default: ;
    endcase
    res.condition_flag = status_copy[fcs_pkg::BIT_COND];
    return res;
  endfunction

  // Pick an operand pattern, biased toward zeros, infinities, NaNs and ties
  function automatic logic [63:0] pick_operand(bit dbl, logic [63:0] other);
    logic [63:0] v;
    logic [63:0] expm, qbit, fracm, sgn;
    v = {$urandom, $urandom};
    if (dbl) begin
      expm = fcs_pkg::DP_EXP;
      qbit = fcs_pkg::DP_QUIET;
      fracm = fcs_pkg::DP_FRAC;
      sgn = 64'h8000000000000000;
    end else begin
      expm = {32'd0, fcs_pkg::SP_EXP};
      qbit = {32'd0, fcs_pkg::SP_QUIET};
      fracm = {32'd0, fcs_pkg::SP_FRAC};
      sgn = 64'h80000000;
    end
    case ($urandom_range(9))
      1: v = (v & ~(expm | fracm | sgn)) | (v & sgn);
      2: v = (v & ~(expm | fracm)) | expm;
      3: v = (v & ~expm) | expm | qbit;
      4: v = (v & ~(expm | qbit)) | expm | 64'd1;
      5: v = other;
      6: v = other + 64'd1;
      7: v = other ^ sgn;
      default: ;
    endcase
    return v;
  endfunction

  function automatic fcs_pkg::req_t make_compare(bit dbl, logic [63:0] a, logic [63:0] b,
                                                 logic [3:0] pred);
    fcs_pkg::req_t r;
    r = '0;
    r.operation = fcs_pkg::OP_COMPARE;
    r.double_format = dbl;
    r.left_operand = a;
    r.right_operand = b;
    r.predicate = pred;
    return r;
  endfunction

  function automatic fcs_pkg::req_t make_control(fcs_pkg::op_t op, logic [4:0] idx,
                                                 logic [31:0] val);
    fcs_pkg::req_t r;
    r = '0;
    r.operation = op;
    r.control_index = idx;
    r.write_value = val;
    return r;
  endfunction

  // Fill the request queue: directed cases first, then random
  initial begin
    fcs_pkg::req_t r;
    logic [191:0]  raw;
    logic [31:0]   wv;
    int            pick;
    pending_reqs.push_back(make_control(fcs_pkg::OP_READ, fcs_pkg::IDX_IMPL, 32'd0));
    pending_reqs.push_back(make_control(fcs_pkg::OP_READ, fcs_pkg::IDX_STATUS, 32'd0));
    pending_reqs.push_back(make_compare(1'b0, 64'h0, 64'h80000000, 4'h2));
    pending_reqs.push_back(make_compare(1'b1, 64'h8000000000000000, 64'h0, 4'h2));
    pending_reqs.push_back(make_compare(1'b0, 64'hffffffff_bf800000, 64'h3f800000, 4'h4));
    pending_reqs.push_back(make_compare(1'b1, 64'h7ff0000000000000,
                                        64'hfff0000000000000, 4'h4));
    pending_reqs.push_back(make_compare(1'b0, 64'h7fc00000, 64'h0, 4'h1));
    pending_reqs.push_back(make_compare(1'b0, 64'h7f800001, 64'h0, 4'h1));
    pending_reqs.push_back(make_compare(1'b0, 64'h7f800001, 64'h0, 4'h9));
    pending_reqs.push_back(make_compare(1'b1, 64'h7ff8000000000000,
                                        64'h7ff0000000000001, 4'hf));
    pending_reqs.push_back(make_compare(1'b1, 64'hffffffffffffffff,
                                        64'hffffffffffffffff, 4'h7));
    pending_reqs.push_back(make_control(fcs_pkg::OP_READ, fcs_pkg::IDX_STATUS, 32'd0));
    // Enable invalid, then trap on two NaN operands
    pending_reqs.push_back(make_control(fcs_pkg::OP_WRITE, fcs_pkg::IDX_STATUS,
                                        32'h0000_0800));
    pending_reqs.push_back(make_compare(1'b0, 64'h7fc00000, 64'h7fc00000, 4'h1));
    pending_reqs.push_back(make_compare(1'b1, 64'h1, 64'h7ff0000000000001, 4'h8));
    pending_reqs.push_back(make_control(fcs_pkg::OP_READ, fcs_pkg::IDX_STATUS, 32'd0));
    // Unimplemented cause and an enabled cause both trap
    pending_reqs.push_back(make_control(fcs_pkg::OP_WRITE, fcs_pkg::IDX_STATUS,
                                        32'h0002_0000));
    pending_reqs.push_back(make_control(fcs_pkg::OP_WRITE, fcs_pkg::IDX_STATUS,
                                        32'hffff_ffff));
    pending_reqs.push_back(make_control(fcs_pkg::OP_READ, fcs_pkg::IDX_STATUS, 32'd0));
    pending_reqs.push_back(make_control(fcs_pkg::OP_WRITE, 5'd5, 32'h0000_0000));
    pending_reqs.push_back(make_control(fcs_pkg::OP_READ, 5'd7, 32'd0));
    pending_reqs.push_back(make_control(fcs_pkg::OP_NONE, fcs_pkg::IDX_STATUS,
                                        32'hffff_ffff));
    pending_reqs.push_back(make_control(fcs_pkg::OP_WRITE, fcs_pkg::IDX_STATUS,
                                        32'h0000_0000));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(fcs_pkg::req_t)-1:0];
      pick = $urandom_range(99);
      if (pick < 60) begin
        r.operation = fcs_pkg::OP_COMPARE;
        r.left_operand = pick_operand(r.double_format, r.right_operand);
        r.right_operand = pick_operand(r.double_format, r.left_operand);
      end else if (pick < 76) begin
        r.operation = fcs_pkg::OP_WRITE;
        wv = r.write_value;
        if ($urandom_range(1)) wv[17] = 1'b0;
        if ($urandom_range(1)) wv[11:7] = 5'd0;
        r.write_value = wv;
        if ($urandom_range(3) != 0) r.control_index = fcs_pkg::IDX_STATUS;
      end else if (pick < 95) begin
        r.operation = fcs_pkg::OP_READ;
        case ($urandom_range(2))
          0: r.control_index = fcs_pkg::IDX_STATUS;
          1: r.control_index = fcs_pkg::IDX_IMPL;
          default: ;
        endcase
      end else begin
        r.operation = fcs_pkg::OP_NONE;
      end
      pending_reqs.push_back(r);
    end
  end

  // Driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk) begin
    bit            offer;
    fcs_pkg::req_t next_req;
    offer = 1'b0;
    next_req = in_ch.data;
    if (!rst_n) begin
      status_copy = 32'd0;
      sent_count <= 0;
      paused_once <= 1'b0;
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rsps.push_back(predict_status(in_ch.data));
        sent_count <= sent_count + 1;
      end else if (in_ch.valid) begin
        offer = 1'b1;
      end
      if (!offer && pending_reqs.size() != 0) begin
        // Hold off once until every expected result has come back
        if (sent_count + (in_ch.valid && in_ch.ready) == PAUSE_AT && !paused_once) begin
          if (expected_rsps.size() == 0 && !(in_ch.valid && in_ch.ready))
            paused_once <= 1'b1;
        end else if ((sent_count >= 100 && sent_count < 250) ||
                     $urandom_range(99) >= 31) begin
          next_req = pending_reqs.pop_front();
          offer = 1'b1;
        end
      end
      in_ch.valid <= offer;
      in_ch.data <= next_req;
    end
  end

  // Receiver back-pressure, with one long hold-off and one long always-ready window
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= 400 && cycle_count < 600) out_ch.ready <= 1'b0;
      else if (cycle_count >= 900 && cycle_count < 1100) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 31);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    fcs_pkg::rsp_t got, want;
    if (!rst_n) begin
      mismatch_count <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_rsps.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %h", got);
      end else begin
        want = expected_rsps.pop_front();
        if (got.condition_flag !== want.condition_flag ||
            got.fp_exception !== want.fp_exception ||
            got.read_data !== want.read_data) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: cond %b/%b exc %b/%b read %h/%h (exp/act)",
                     want.condition_flag, got.condition_flag,
                     want.fp_exception, got.fp_exception,
                     want.read_data, got.read_data);
        end
      end
    end
  end

  // End of run
  initial begin
    @(posedge rst_n);
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_rsps.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hdl/fcs_pkg.sv
hdl/fcs_if.sv
hdl/fcs_cmp.sv
hdl/fpu_compare_and_status_top.sv
hdl/fcs_checker.sv
tb/sv/testbench.sv
